// ----- sv/mqtt_frame_parser_assert.svh -----
// assertion macros shared by the checker of the frame parser
`ifndef MQTT_FRAME_PARSER_ASSERT_SVH
`define MQTT_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mfp_pkg.sv -----
// package of the frame parser: types, codes and defaults
package mfp_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;

  localparam logic [3:0] PUBLISH_TYPE = 4'd3;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LEN,
    PH_BODY
  } mfp_phase_e;

  typedef enum logic [2:0] {
    ST_CONTROL_OK = 3'd0,
    ST_PUBLISH_OK = 3'd1,
    ST_MALFORMED  = 3'd2,
    ST_NO_TOPIC   = 3'd3,
    ST_HDR_OVER   = 3'd4
  } mfp_status_e;

  // byte held in the input register
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } mfp_stage_t;

  typedef struct packed {
    mfp_status_e frame_status;
    logic [3:0]  pkt_type;
    logic [3:0]  header_flags;
    logic [27:0] rem_length;
    logic [2:0]  length_field_bytes;
    logic [28:0] frame_bytes;
    logic [1:0]  qos_level;
    logic [15:0] topic_len;
    logic [28:0] pay_offset;
    logic [27:0] pay_size;
    logic        payload_opaque;
  } mfp_result_t;

endpackage

// ----- sv/mfp_if.sv -----
// valid/ready channel interfaces: stream bytes in, frame results out
interface mfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mfp_frame_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [3:0]  pkt_type;
  logic [3:0]  header_flags;
  logic [27:0] rem_length;
  logic [2:0]  length_field_bytes;
  logic [28:0] frame_bytes;
  logic [1:0]  qos_level;
  logic [15:0] topic_len;
  logic [28:0] pay_offset;
  logic [27:0] pay_size;
  logic        payload_opaque;

  modport source (
    output valid, input ready,
    output frame_status, output pkt_type, output header_flags,
    output rem_length, output length_field_bytes, output frame_bytes,
    output qos_level, output topic_len, output pay_offset,
    output pay_size, output payload_opaque
  );
  modport sink (
    input valid, output ready,
    input frame_status, input pkt_type, input header_flags,
    input rem_length, input length_field_bytes, input frame_bytes,
    input qos_level, input topic_len, input pay_offset,
    input pay_size, input payload_opaque
  );
endinterface

// ----- sv/mqtt_frame_parser.sv -----
// MQTT frame parser: splits a byte stream into control packets, one result per frame
//
// byte_i takes one stream byte per item; frame_o gives one item per frame end
// (or at once when the last allowed length byte still has its continuation bit),
// with the fixed-header facts, the publish layout and a status code.
// A byte passes an input register and the parser core, which updates the frame
// state and loads the result register in the same cycle.
// A byte that ends a frame passes the input register and the core, and its result
// is loaded into the result register that drives frame_o.
// Throughput: one byte per cycle while frame_o takes results, including frame ends.
// While a result waits on a stalled frame_o the core holds its byte; the input
// register takes at most one more byte, then byte_i.ready drops until the
// result is taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to waiting for the first byte of a frame; there is no clearing pass.
module mqtt_frame_parser import mfp_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfp_byte_if.sink    byte_i,
  mfp_frame_if.source frame_o
);

  mfp_stage_t stage;
  logic       advance;

  mfp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  mfp_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .frame_o   (frame_o)
  );

endmodule

// ----- sv/mfp_in_reg.sv -----
// input register stage: holds one stream byte until the parser core takes it
module mfp_in_reg import mfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfp_byte_if.sink   byte_i,
  input  logic       advance_i,
  output mfp_stage_t stage_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;
  logic       accept;

  assign byte_i.ready = advance_i || !vld_q;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (advance_i) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= byte_i.data_byte;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.data = data_q;

endmodule

// ----- sv/mfp_core.sv -----
// parser core: frame state, header decode and the result register
module mfp_core import mfp_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mfp_stage_t stage_i,
  output logic       advance_o,
  mfp_frame_if.source frame_o
);

  localparam int CntW = $clog2(MAX_LENGTH_BYTES + 1);

  function automatic logic is_text(input logic [7:0] b);
    is_text = (b >= 8'h20 && b <= 8'h7e) || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  mfp_phase_e  phase_q, phase_d;
  logic [7:0]  first_q, first_d;
  logic [27:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [27:0] body_q, body_d;
  logic [15:0] topic_q, topic_d;
  logic        opq_q, opq_d;
  logic        res_vld_q, res_vld_d;
  mfp_result_t res_q, res_d;

  logic [7:0]  b;
  logic        take;
  logic        is_pub;
  logic [1:0]  qos;
  logic [16:0] qos_add;
  logic [4:0]  shamt;
  logic [27:0] acc_len;
  logic [CntW-1:0] cnt_inc;
  logic        malformed;
  logic        len_zero;
  logic [27:0] body_inc;
  logic        body_end;
  logic [16:0] vh_cur;
  logic [15:0] topic_nx;
  logic        opq_nx;
  logic [27:0] fin_rem;
  logic [CntW-1:0] fin_cnt;
  logic [16:0] fin_vh;
  logic [28:0] hdr;
  mfp_result_t fin_res, mal_res;

  assign advance_o = !res_vld_q || frame_o.ready;
  assign b         = stage_i.data;
  assign take      = advance_o && stage_i.vld;

  // decode and frame-end results
  always_comb begin
    is_pub    = first_q[7:4] == PUBLISH_TYPE;
    qos       = is_pub ? first_q[2:1] : 2'd0;
    qos_add   = (qos != 2'd0) ? 17'd2 : 17'd0;

    // length groups never overlap, so or-ing equals the add
    shamt     = 5'(cnt_q) * 5'd7;
    acc_len   = acc_q | (28'(b[6:0]) << shamt);
    cnt_inc   = cnt_q + CntW'(1);
    malformed = b[7] && (cnt_inc >= CntW'(MAX_LENGTH_BYTES));
    len_zero  = !b[7] && (acc_len == 28'd0);

    body_inc  = body_q + 28'd1;
    body_end  = body_inc >= acc_q;
    vh_cur    = 17'd2 + 17'(topic_q) + qos_add;

    topic_nx  = topic_q;
    opq_nx    = opq_q;
    if (is_pub) begin
      if (body_q == 28'd0) begin
        topic_nx = {b, 8'h00};
      end else if (body_q == 28'd1) begin
        topic_nx = {topic_q[15:8], b};
      end else if (body_q >= 28'(vh_cur) && !is_text(b)) begin
        opq_nx = 1'b1;
      end
    end

    fin_rem = (phase_q == PH_LEN) ? acc_len : acc_q;
    fin_cnt = (phase_q == PH_LEN) ? cnt_inc : cnt_q;
    fin_vh  = 17'd2 + 17'(topic_nx) + qos_add;
    hdr     = 29'(fin_cnt) + 29'd1;

    fin_res.frame_status       = ST_CONTROL_OK;
    fin_res.pkt_type           = first_q[7:4];
    fin_res.header_flags       = first_q[3:0];
    fin_res.rem_length         = fin_rem;
    fin_res.length_field_bytes = 3'(fin_cnt);
    fin_res.frame_bytes        = hdr + 29'(fin_rem);
    fin_res.qos_level          = qos;
    fin_res.topic_len          = 16'd0;
    fin_res.pay_offset         = 29'd0;
    fin_res.pay_size           = 28'd0;
    fin_res.payload_opaque     = 1'b0;
    if (!is_pub) begin
      fin_res.frame_status = ST_CONTROL_OK;
    end else if (fin_rem < 28'd2) begin
      fin_res.frame_status = ST_NO_TOPIC;
    end else if (28'(fin_vh) > fin_rem) begin
      fin_res.frame_status = ST_HDR_OVER;
      fin_res.topic_len    = topic_nx;
    end else begin
      fin_res.frame_status   = ST_PUBLISH_OK;
      fin_res.topic_len      = topic_nx;
      fin_res.pay_offset     = hdr + 29'(fin_vh);
      fin_res.pay_size       = fin_rem - 28'(fin_vh);
      fin_res.payload_opaque = opq_nx;
    end

    mal_res                    = '0;
    mal_res.frame_status       = ST_MALFORMED;
    mal_res.pkt_type           = first_q[7:4];
    mal_res.header_flags       = first_q[3:0];
    mal_res.length_field_bytes = 3'(cnt_inc);
    mal_res.qos_level          = qos;
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_FIRST: begin
        if (take) phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (take) begin
          if (b[7]) begin
            phase_d = malformed ? PH_FIRST : PH_LEN;
          end else begin
            phase_d = len_zero ? PH_FIRST : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (take && body_end) phase_d = PH_FIRST;
      end
      default: phase_d = PH_FIRST;
    endcase
  end

  // frame state and result register updates
  always_comb begin
    first_d   = first_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    body_d    = body_q;
    topic_d   = topic_q;
    opq_d     = opq_q;
    res_vld_d = res_vld_q && !frame_o.ready;
    res_d     = res_q;
    if (take) begin
      unique case (phase_q)
        PH_FIRST: begin
          first_d = b;
          acc_d   = 28'd0;
          cnt_d   = '0;
          body_d  = 28'd0;
          topic_d = 16'd0;
          opq_d   = 1'b0;
        end
        PH_LEN: begin
          acc_d = acc_len;
          cnt_d = cnt_inc;
          if (malformed) begin
            res_vld_d = 1'b1;
            res_d     = mal_res;
          end else if (len_zero) begin
            res_vld_d = 1'b1;
            res_d     = fin_res;
          end
        end
        PH_BODY: begin
          topic_d = topic_nx;
          opq_d   = opq_nx;
          body_d  = body_inc;
          if (body_end) begin
            res_vld_d = 1'b1;
            res_d     = fin_res;
          end
        end
        default: begin
          first_d = first_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      first_q   <= 8'd0;
      acc_q     <= 28'd0;
      cnt_q     <= '0;
      body_q    <= 28'd0;
      topic_q   <= 16'd0;
      opq_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      body_q    <= body_d;
      topic_q   <= topic_d;
      opq_q     <= opq_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign frame_o.valid              = res_vld_q;
  assign frame_o.frame_status       = res_q.frame_status;
  assign frame_o.pkt_type           = res_q.pkt_type;
  assign frame_o.header_flags       = res_q.header_flags;
  assign frame_o.rem_length         = res_q.rem_length;
  assign frame_o.length_field_bytes = res_q.length_field_bytes;
  assign frame_o.frame_bytes        = res_q.frame_bytes;
  assign frame_o.qos_level          = res_q.qos_level;
  assign frame_o.topic_len          = res_q.topic_len;
  assign frame_o.pay_offset         = res_q.pay_offset;
  assign frame_o.pay_size           = res_q.pay_size;
  assign frame_o.payload_opaque     = res_q.payload_opaque;

endmodule

// ----- sv/mfp_checker.sv -----
// port-level checker of the frame parser and its bind to the top level
`include "mqtt_frame_parser_assert.svh"

module mfp_checker import mfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [28:0] frame_bytes_i,
  input logic [28:0] pay_offset_i,
  input logic [27:0] pay_size_i,
  input logic        payload_opaque_i
);

  logic        stalled;
  logic        pub_ok;
  logic        other_res;
  logic        span_ok;
  logic        pay_clear;
  logic [89:0] held_bits;

  assign stalled   = out_valid_i && !out_ready_i;
  assign pub_ok    = out_valid_i && status_i == 3'(ST_PUBLISH_OK);
  assign other_res = out_valid_i && status_i != 3'(ST_PUBLISH_OK);
  assign span_ok   = 29'(pay_offset_i + 29'(pay_size_i)) == frame_bytes_i;
  assign pay_clear = pay_offset_i == 29'd0 && pay_size_i == 28'd0 && !payload_opaque_i;
  assign held_bits = {status_i, frame_bytes_i, pay_offset_i, pay_size_i, payload_opaque_i};

  // a stalled result stays put
  `MFP_ASSERT_NXT(a_out_hold, stalled, out_valid_i && $stable(held_bits), "stalled result moved")

  // input backpressure only comes from a stalled result
  `MFP_ASSERT_IMP(a_in_stall, !in_ready_i, stalled, "input stalled without output stall")

  // publish payload ends exactly at the frame end
  `MFP_ASSERT_IMP(a_pub_span, pub_ok, span_ok, "publish payload does not end at frame end")

  // payload fields are zero unless the publish parsed cleanly
  `MFP_ASSERT_IMP(a_pay_zero, other_res, pay_clear, "payload fields set on a non-publish result")

endmodule

bind mqtt_frame_parser mfp_checker u_mfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (byte_i.ready),
  .out_valid_i      (frame_o.valid),
  .out_ready_i      (frame_o.ready),
  .status_i         (frame_o.frame_status),
  .frame_bytes_i    (frame_o.frame_bytes),
  .pay_offset_i     (frame_o.pay_offset),
  .pay_size_i       (frame_o.pay_size),
  .payload_opaque_i (frame_o.payload_opaque)
);
